[src/b2da_pkg.sv]
// shared constants and digit helpers for the binary to decimal ascii converter
package b2da_pkg;

    localparam int VALUE_W   = 64;
    localparam int DIGITS    = 20;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int CHAR_W    = 6;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int REM_W     = $clog2(DIGITS + 1);

    // ascii '0' in the six bits of the result field
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [3:0]        DEC_HALF   = 4'd5;
    localparam logic [3:0]        DEC_ADJ    = 4'd3;

    // add-3 correction of one bcd digit before it is doubled
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= DEC_HALF) ? (d + DEC_ADJ) : d;
        return r;
    endfunction

endpackage

[src/binary_to_decimal_ascii_top.sv]
// binary to decimal ascii converter: shift-add-3 sequencer and digit output stage
//
//  channel | ports                                  | direction | carries
//  --------+----------------------------------------+-----------+-------------------------
//  s_      | s_valid s_ready s_value[63:0]          | in        | one number per request
//  m_      | m_valid m_ready m_digit_char[5:0]      | out       | one ascii digit per request
//          | m_last_digit                           |           | set on the final digit
//
//  a number is accepted, then shifted through the shared shift-add-3 unit in 64 steps (one input
//  bit per cycle), then its leading zeros are dropped, and then its digits leave one by one,
//  most significant first
//  s_ready is high only while the sequencer is idle; the output register lets the last
//  digit wait for the sink while the next number is already taken in
//  a stalled sink holds the digit in the output register and pauses the digit phase
//  aresetn is synchronous, active low, and clears the sequencer and output valid
module binary_to_decimal_ascii_top
    import b2da_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [VALUE_W-1:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAR_W-1:0]    m_digit_char,
    output logic                 m_last_digit
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [VALUE_W-1:0]    val_reg;      // input bits still to be shifted in, msb first
    logic [BCD_W-1:0]      bcd_reg;      // 20 bcd digits, most significant on top
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;  // conversion steps left minus one
    logic [REM_W-1:0]      remain_reg;   // digits still to leave, leading zeros included
    logic                  m_valid_reg;
    logic [CHAR_W-1:0]     m_digit_char_reg;
    logic                  m_last_digit_reg;

    logic [BCD_W-1:0]      bcd_adj;
    logic [BCD_W-1:0]      bcd_step;
    logic [3:0]            top_digit;
    logic                  out_free;

    // shared unit: add-3 on every digit, then shift the next input bit in
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            bcd_adj[4*i +: 4] = bcd_adjust(bcd_reg[4*i +: 4]);
        end
        bcd_step = {bcd_adj[BCD_W-2:0], val_reg[VALUE_W-1]};
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    // the output register can take a digit when empty or being drained
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // outside the digit phase a drained digit empties the output register
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        val_reg     <= s_value;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= BIT_CNT_W'(VALUE_W - 1);
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    val_reg <= {val_reg[VALUE_W-2:0], 1'b0};
                    bcd_reg <= bcd_step;
                    if (bit_cnt_reg == '0) begin
                        remain_reg <= REM_W'(DIGITS);
                        state_reg  <= ST_SKIP;
                    end else begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
                ST_SKIP: begin
                    // drop leading zeros but always keep the units digit
                    if (top_digit == 4'd0 && remain_reg > REM_W'(1)) begin
                        bcd_reg    <= {bcd_reg[BCD_W-5:0], 4'd0};
                        remain_reg <= remain_reg - 1'b1;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_digit_char_reg <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
                        m_last_digit_reg <= (remain_reg == REM_W'(1));
                        bcd_reg          <= {bcd_reg[BCD_W-5:0], 4'd0};
                        remain_reg       <= remain_reg - 1'b1;
                        if (remain_reg == REM_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_digit_char_reg;
    assign m_last_digit = m_last_digit_reg;

    // an accepted number starts a full 64-step conversion
    a_start_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_CONV && bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
        else $error("conversion did not start after accept");

    // the step counter falls by one each conversion cycle
    a_conv_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV && bit_cnt_reg != '0 |=>
            state_reg == ST_CONV && bit_cnt_reg == $past(bit_cnt_reg) - 1'b1)
        else $error("conversion step counter skipped");

    // the digit count never exceeds the widest number
    a_remain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SKIP || state_reg == ST_EMIT |-> remain_reg <= REM_W'(DIGITS)
            && remain_reg != '0)
        else $error("digit count out of range");

    // every digit leaving is a decimal digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit_char >= ASCII_ZERO && m_digit_char <= ASCII_ZERO + CHAR_W'(9))
        else $error("output digit not decimal");

endmodule

[verif/binary_to_decimal_ascii_top_tb.sv]
// testbench for the binary to decimal ascii converter: random traffic, digit-by-digit checks
module binary_to_decimal_ascii_top_tb
    import b2da_pkg::*;
();

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_NUMBERS = 260;
    // cycles in a row with no request taken on either side before giving up
    localparam int STALL_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int DEC_BASE       = 10;
    localparam int POW10_MAX      = 19;

    // idle percentages per traffic phase
    localparam int SEND_IDLE_A = 15;
    localparam int SINK_IDLE_A = 71;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } digit_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAR_W-1:0]  m_digit_char;
    logic               m_last_digit;

    logic [VALUE_W-1:0] numbers_to_send[$];
    digit_t             expected_digits[$];
    int                 numbers_total = 1;
    int                 numbers_taken = 0;
    int                 error_count   = 0;
    int                 quiet_cycles  = 0;

    binary_to_decimal_ascii_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // decimal text of one number, most significant digit first, no leading zeros
    function automatic void predict_digits(input logic [VALUE_W-1:0] number);
        logic [3:0]         digits[DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 count;
        digit_t             d;
        rest  = number;
        count = 0;
        do begin
            digits[count] = 4'(rest % DEC_BASE);
            rest          = rest / DEC_BASE;
            count++;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            d.digit_char = ASCII_ZERO + CHAR_W'(digits[k]);
            d.last_digit = (k == 0);
            expected_digits.push_back(d);
        end
    endfunction

    // mostly numbers of random bit length, some near powers of ten, some full width
    function automatic logic [VALUE_W-1:0] random_number();
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] pow;
        int                 kind;
        int                 len;
        int                 exp10;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(9);
        if (kind < 6) begin
            len = $urandom_range(VALUE_W, 1);
            return raw >> (VALUE_W - len);
        end else if (kind < 8) begin
            pow   = VALUE_W'(1);
            exp10 = $urandom_range(POW10_MAX);
            repeat (exp10) pow = pow * VALUE_W'(DEC_BASE);
            return pow - VALUE_W'(1) + VALUE_W'($urandom_range(2));
        end
        return raw;
    endfunction

    // driver: request side and sink ready, both from the current traffic phase
    always @(posedge aclk) begin
        int phase;
        int send_idle;
        int sink_idle;
        phase = (numbers_taken * 3) / numbers_total;
        // first phase: sender rarely idle, sink mostly stalled; then swapped; then none
        send_idle = (phase == 0) ? SEND_IDLE_A : (phase == 1) ? SINK_IDLE_A : 0;
        sink_idle = (phase == 0) ? SINK_IDLE_A : (phase == 1) ? SEND_IDLE_A : 0;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) numbers_taken++;
            // a held request is never dropped; a new one goes out only when the slot is free
            if (!s_valid || s_ready) begin
                if (numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_valid <= 1'b1;
                    s_value <= numbers_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // monitor: predicts on each taken number, checks each digit, watches for a hang
    always @(posedge aclk) begin
        digit_t want;
        if (aresetn) begin
            if (s_valid && s_ready) predict_digits(s_value);
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    $error("digit request with nothing expected: digit_char %0d last_digit %0d",
                           m_digit_char, m_last_digit);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (m_digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d", want.digit_char, m_digit_char);
                        error_count++;
                    end
                    if (m_last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0d, got %0d", want.last_digit, m_last_digit);
                        error_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        // zero, single digits, carries into a new digit and the 32-bit boundary
        numbers_to_send.push_back(64'd0);
        numbers_to_send.push_back(64'd1);
        numbers_to_send.push_back(64'd9);
        numbers_to_send.push_back(64'd10);
        numbers_to_send.push_back(64'd99);
        numbers_to_send.push_back(64'd100);
        numbers_to_send.push_back(64'd4294967295);
        numbers_to_send.push_back(64'd4294967296);
        numbers_to_send.push_back(64'd1000000000000000000);
        // largest 19-digit value, then the 20-digit range and other wide values
        numbers_to_send.push_back(64'd9999999999999999999);
        numbers_to_send.push_back(64'd10000000000000000000);
        numbers_to_send.push_back(64'd12345678901234567890);
        numbers_to_send.push_back(64'd9223372036854775807);
        numbers_to_send.push_back(64'd9223372036854775808);
        numbers_to_send.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        numbers_to_send.push_back(64'h5555_5555_5555_5555);
        numbers_to_send.push_back(64'd18446744073709551615);
        numbers_to_send.push_back(64'd1234567890123456789);
        repeat (RANDOM_NUMBERS) numbers_to_send.push_back(random_number());
        numbers_total = numbers_to_send.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // every number taken, then one more edge so its digits are predicted
        while (numbers_taken < numbers_total) @(posedge aclk);
        @(posedge aclk);
        while (expected_digits.size() != 0) @(posedge aclk);
        // let any late stray digit show up
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_digits.size() != 0) begin
            $error("%0d expected digits never arrived", expected_digits.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
src/b2da_pkg.sv
src/binary_to_decimal_ascii_top.sv
verif/binary_to_decimal_ascii_top_tb.sv
